// ===== src/mlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types for the multi-level priority queue: result status codes and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mlpq_pkg;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic       capture;
      logic       enq_commit;
      logic       deq_commit;
      logic       rsp_load;
      logic       rsp_fetch;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic is_deq;
      logic enq_reject;
      logic all_empty;
   } stat_type;

endpackage

// ===== src/multi_level_priority_queue.sv =====
// ----------------------------------------------------------------------------
// multi_level_priority_queue
// Strict-priority queue: one circular FIFO of entry handles per level.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Enqueues and dequeues
// that find every level empty give their result from the evaluate state; a
// successful dequeue goes on to the fetch state, as the head pointer memory
// read is followed by the entry memory read. busy falls in the cycle the result
// is shown, so a new request may be taken alongside rsp_strobe. rsp_strobe is
// high for one cycle per result and the receiver cannot hold it off. No
// clearing pass is needed after reset. Each level holds at most DEPTH-1
// entries.
module multi_level_priority_queue #(
   parameter int LEVELS      = 8,
   parameter int DEPTH       = 128,
   parameter int HANDLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_action,
   input  logic [2:0]             req_level,
   input  logic [HANDLE_BITS-1:0] req_entry_handle,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_served_handle,
   output logic [2:0]             rsp_served_level
);

   import mlpq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mlpq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   mlpq_datapath #(
      .LEVELS      (LEVELS),
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_level         (req_level),
      .req_entry_handle  (req_entry_handle),
      .rsp_status        (rsp_status),
      .rsp_served_handle (rsp_served_handle),
      .rsp_served_level  (rsp_served_level)
   );

endmodule

// ===== src/mlpq_ram.sv =====
// ----------------------------------------------------------------------------
// mlpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mlpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mlpq_datapath.sv =====
// ----------------------------------------------------------------------------
// mlpq_datapath
// Request capture, level selection, head/tail pointer and entry memories,
// non-empty flags and the result registers.
// ----------------------------------------------------------------------------
module mlpq_datapath #(
   parameter int LEVELS      = 8,
   parameter int DEPTH       = 128,
   parameter int HANDLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mlpq_pkg::cmd_type      cmd,
   output mlpq_pkg::stat_type     stat,
   input  logic                   req_action,
   input  logic [2:0]             req_level,
   input  logic [HANDLE_BITS-1:0] req_entry_handle,
   output logic [1:0]             rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_served_handle,
   output logic [2:0]             rsp_served_level
);

   import mlpq_pkg::*;

   localparam int LW = $clog2(LEVELS);
   localparam int PW = $clog2(DEPTH);
   localparam int ED = LEVELS << PW;

   logic                   action_ff, action_in;
   logic [LW-1:0]          sel_ff, sel_in;
   logic                   oor_ff, oor_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [LEVELS-1:0]      nonempty_ff, nonempty_in;
   logic [LEVELS-1:0]      head_valid_ff, head_valid_in;
   logic [LEVELS-1:0]      tail_valid_ff, tail_valid_in;
   status_type             status_ff, status_in;
   logic [HANDLE_BITS-1:0] served_handle_ff, served_handle_in;
   logic [2:0]             served_level_ff, served_level_in;

   logic [LW-1:0]          enc_sel;
   logic [LW-1:0]          ptr_raddr;
   logic [PW-1:0]          head_rdata, tail_rdata;
   logic [PW-1:0]          head, tail, next_head, next_tail;
   logic [HANDLE_BITS-1:0] entry_rdata;

   // lowest-numbered non-empty level
   always_comb begin
      enc_sel = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            enc_sel = LW'(i);
         end
      end
   end

   assign ptr_raddr = req_action ? enc_sel : LW'(req_level);

   mlpq_ram #(.WIDTH(PW), .DEPTH(LEVELS)) u_head_ram (
      .clock   (clock),
      .wr_en   (cmd.deq_commit),
      .wr_addr (sel_ff),
      .wr_data (next_head),
      .rd_addr (ptr_raddr),
      .rd_data (head_rdata)
   );

   mlpq_ram #(.WIDTH(PW), .DEPTH(LEVELS)) u_tail_ram (
      .clock   (clock),
      .wr_en   (cmd.enq_commit),
      .wr_addr (sel_ff),
      .wr_data (next_tail),
      .rd_addr (ptr_raddr),
      .rd_data (tail_rdata)
   );

   mlpq_ram #(.WIDTH(HANDLE_BITS), .DEPTH(ED)) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.enq_commit),
      .wr_addr ({sel_ff, tail}),
      .wr_data (handle_ff),
      .rd_addr ({sel_ff, head}),
      .rd_data (entry_rdata)
   );

   // pointers never written read as zero
   assign head      = head_valid_ff[sel_ff] ? head_rdata : '0;
   assign tail      = tail_valid_ff[sel_ff] ? tail_rdata : '0;
   assign next_head = (head == PW'(DEPTH - 1)) ? '0 : PW'(head + PW'(1));
   assign next_tail = (tail == PW'(DEPTH - 1)) ? '0 : PW'(tail + PW'(1));

   assign stat.is_deq     = action_ff;
   assign stat.enq_reject = oor_ff || (next_tail == head);
   assign stat.all_empty  = ~|nonempty_ff;

   always_comb begin
      action_in        = action_ff;
      sel_in           = sel_ff;
      oor_in           = oor_ff;
      handle_in        = handle_ff;
      nonempty_in      = nonempty_ff;
      head_valid_in    = head_valid_ff;
      tail_valid_in    = tail_valid_ff;
      status_in        = status_ff;
      served_handle_in = served_handle_ff;
      served_level_in  = served_level_ff;
      if (cmd.capture) begin
         action_in = req_action;
         sel_in    = ptr_raddr;
         oor_in    = !req_action && (int'(req_level) >= LEVELS);
         handle_in = req_entry_handle;
      end
      if (cmd.enq_commit) begin
         nonempty_in[sel_ff]   = 1'b1;
         tail_valid_in[sel_ff] = 1'b1;
      end
      if (cmd.deq_commit) begin
         head_valid_in[sel_ff] = 1'b1;
         if (next_head == tail) begin
            nonempty_in[sel_ff] = 1'b0;
         end
      end
      if (cmd.rsp_load) begin
         status_in        = cmd.rsp_status;
         served_handle_in = cmd.rsp_fetch ? entry_rdata : '0;
         served_level_in  = cmd.rsp_fetch ? 3'(sel_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff   <= '0;
         head_valid_ff <= '0;
         tail_valid_ff <= '0;
      end else begin
         nonempty_ff   <= nonempty_in;
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
      action_ff        <= action_in;
      sel_ff           <= sel_in;
      oor_ff           <= oor_in;
      handle_ff        <= handle_in;
      status_ff        <= status_in;
      served_handle_ff <= served_handle_in;
      served_level_ff  <= served_level_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_served_handle = served_handle_ff;
   assign rsp_served_level  = served_level_ff;

endmodule

// ===== src/mlpq_controller.sv =====
// ----------------------------------------------------------------------------
// mlpq_controller
// Sequencer for one request: pointer read, evaluate and commit, entry fetch
// on a successful dequeue, result strobe.
// ----------------------------------------------------------------------------
module mlpq_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output mlpq_pkg::cmd_type   cmd,
   input  mlpq_pkg::stat_type  stat
);

   import mlpq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_FETCH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_strobe_ff, rsp_strobe_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = STATUS_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_IDLE;
            if (stat.is_deq) begin
               if (stat.all_empty) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = STATUS_EMPTY;
               end else begin
                  cmd.deq_commit = 1'b1;
                  state_in       = S_FETCH;
               end
            end else begin
               cmd.rsp_load = 1'b1;
               if (stat.enq_reject) begin
                  cmd.rsp_status = STATUS_FULL;
               end else begin
                  cmd.enq_commit = 1'b1;
               end
            end
         end
         S_FETCH: begin
            cmd.rsp_load  = 1'b1;
            cmd.rsp_fetch = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in       = (state_in != S_IDLE);
      rsp_strobe_in = cmd.rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule
